// File: rtl/chd_pkg.sv
// Shared types, constants and the arctangent table of the compass heading block.
package chd_pkg;

	// Width of one magnetometer axis and of the heading.
	localparam int MAG_W = 16;
	// CORDIC x/y datapath: 16-bit axis scaled by 2^8, one bit for negation, two for gain.
	localparam int XY_W = 27;
	// Guard shift applied to x and y before the rotations.
	localparam int GUARD_SHIFT = 8;
	// One eighth of pi in 16-bit binary angle units.
	localparam int EIGHTH = 4096;
	// Width of the band half-width register.
	localparam int BAND_W = 13;
	localparam int LED_W = 8;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOW = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BAND = 2'd2;

	// Arctangent of 2^-i with pi = 2^31.
	localparam logic [31:0] ATAN_TAB [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// How the z reading decides the LEDs.
	typedef enum logic [1:0] {
		ZCLS_COMPASS,
		ZCLS_ALL_ON,
		ZCLS_ALL_OFF
	} zcls_t;

	// Side information that rides along the CORDIC stages.
	typedef struct packed {
		logic  zero_vec;
		zcls_t zcls;
	} side_t;

	// Arctangent step i rounded to nearest for an accumulator with pi = 2^(ab-1).
	function automatic logic [31:0] atan_step(input int unsigned ab, input int unsigned i);
		logic [32:0] t;
		t = {1'b0, ATAN_TAB[5'(i)]} + (33'd1 << (31 - ab));
		return t[32:1] >> (31 - ab);
	endfunction

endpackage

// File: rtl/chd_if.sv
// Valid/ready channel interfaces for magnetometer samples and compass results.
interface chd_sample_if;
	logic                               valid;
	logic                               ready;
	logic signed [chd_pkg::MAG_W-1:0]   mag_x;
	logic signed [chd_pkg::MAG_W-1:0]   mag_y;
	logic signed [chd_pkg::MAG_W-1:0]   mag_z;

	modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
	modport sink (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface chd_result_if;
	logic                               valid;
	logic                               ready;
	logic [chd_pkg::LED_W-1:0]          led_pattern;
	logic signed [chd_pkg::MAG_W-1:0]   heading_angle;

	modport source (output valid, output led_pattern, output heading_angle, input ready);
	modport sink (input valid, input led_pattern, input heading_angle, output ready);
endinterface

// File: rtl/compass_heading_led_indicator.sv
// Top level: magnetometer sample to eight-LED compass pattern and heading, fully pipelined.
// Pipeline from an accepted sample beat to its result beat:
// one entry stage, one stage per CORDIC iteration, one rounding stage and one LED stage.
// Throughput: one sample per cycle; every stage holds its own valid bit, so a stalled
// result only blocks the input once all stages in front of it are full.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the limits 240 and -310
// and the band half width 819.
module compass_heading_led_indicator #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	chd_sample_if.sink                           sample,
	chd_result_if.source                         result,
	input  logic                                 cfg_we,
	input  logic [chd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [chd_pkg::MAG_W-1:0]            cfg_wdata
);

	// Fixed comparison points of the LED decode, one eighth of a turn apart.
	localparam logic signed [17:0] Q1 = 18'(chd_pkg::EIGHTH);
	localparam logic signed [17:0] Q3 = 18'(3 * chd_pkg::EIGHTH);
	localparam logic signed [17:0] Q5 = 18'(5 * chd_pkg::EIGHTH);
	localparam logic signed [17:0] Q7 = 18'(7 * chd_pkg::EIGHTH);

	// ------------------------------------------------------------------
	// Configuration registers. The user must change them only while the block is idle; the block does not enforce it.
	// Writes to an index that names no register are dropped.
	// ------------------------------------------------------------------
	logic signed [chd_pkg::MAG_W-1:0]  z_high_q;
	logic signed [chd_pkg::MAG_W-1:0]  z_low_q;
	logic [chd_pkg::BAND_W-1:0]        band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_high_q <= 16'sd240;
			z_low_q <= -16'sd310;
			band_q <= 13'd819;
		end else if (cfg_we) begin
			case (cfg_index)
				chd_pkg::REG_Z_HIGH: z_high_q <= cfg_wdata;
				chd_pkg::REG_Z_LOW:  z_low_q <= cfg_wdata;
				chd_pkg::REG_BAND:   band_q <= cfg_wdata[chd_pkg::BAND_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Entry stage (s1): scale x and y by 2^8, fold the left half plane onto
	// the right one with a starting angle of pi, flag the zero vector and
	// settle the z tests, so that only the heading is left to compute.
	// ------------------------------------------------------------------
	logic                            v_s1;
	logic                            rdy_s1;
	logic signed [chd_pkg::XY_W-1:0] x_s1;
	logic signed [chd_pkg::XY_W-1:0] y_s1;
	logic [ANGLE_BITS-1:0]           z_s1;
	chd_pkg::side_t                  side_s1;

	logic signed [chd_pkg::XY_W-1:0] x_sc;
	logic signed [chd_pkg::XY_W-1:0] y_sc;
	chd_pkg::side_t                  side_in;

	always_comb begin
		x_sc = chd_pkg::XY_W'(sample.mag_x) <<< chd_pkg::GUARD_SHIFT;
		y_sc = chd_pkg::XY_W'(sample.mag_y) <<< chd_pkg::GUARD_SHIFT;
		side_in.zero_vec = (sample.mag_x == '0) && (sample.mag_y == '0);
		// The high test is made first and wins when the limits cross.
		if (sample.mag_z > z_high_q) begin
			side_in.zcls = chd_pkg::ZCLS_ALL_ON;
		end else if (sample.mag_z < z_low_q) begin
			side_in.zcls = chd_pkg::ZCLS_ALL_OFF;
		end else begin
			side_in.zcls = chd_pkg::ZCLS_COMPASS;
		end
	end

	logic [ANGLE_BITS:0] crdy_w;
	logic                cv_w [ANGLE_BITS+1];

	assign rdy_s1 = !v_s1 || crdy_w[0];
	assign sample.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= sample.valid;
		end
	end

	// Plus and minus pi are the same code once the accumulator wraps.
	always_ff @(posedge clk) begin
		if (rdy_s1 && sample.valid) begin
			side_s1 <= side_in;
			if (sample.mag_x[chd_pkg::MAG_W-1]) begin
				x_s1 <= -x_sc;
				y_s1 <= -y_sc;
				z_s1 <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
			end else begin
				x_s1 <= x_sc;
				y_s1 <= y_sc;
				z_s1 <= '0;
			end
		end
	end

	// ------------------------------------------------------------------
	// CORDIC: one registered stage per iteration. The angle accumulator is
	// ANGLE_BITS wide and wraps, which matches reducing it modulo a turn.
	// ------------------------------------------------------------------
	logic signed [chd_pkg::XY_W-1:0] cx_w [ANGLE_BITS+1];
	logic signed [chd_pkg::XY_W-1:0] cy_w [ANGLE_BITS+1];
	logic [ANGLE_BITS-1:0]           cz_w [ANGLE_BITS+1];
	chd_pkg::side_t                  cside_w [ANGLE_BITS+1];

	assign cv_w[0] = v_s1;
	assign cx_w[0] = x_s1;
	assign cy_w[0] = y_s1;
	assign cz_w[0] = z_s1;
	assign cside_w[0] = side_s1;

	for (genvar i = 0; i < ANGLE_BITS; i++) begin : g_cordic
		chd_cordic_stage #(
			.ANGLE_BITS (ANGLE_BITS),
			.STEP       (i)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cv_w[i]),
			.in_ready  (crdy_w[i]),
			.in_x      (cx_w[i]),
			.in_y      (cy_w[i]),
			.in_z      (cz_w[i]),
			.in_side   (cside_w[i]),
			.out_valid (cv_w[i+1]),
			.out_ready (crdy_w[i+1]),
			.out_x     (cx_w[i+1]),
			.out_y     (cy_w[i+1]),
			.out_z     (cz_w[i+1]),
			.out_side  (cside_w[i+1])
		);
	end

	// ------------------------------------------------------------------
	// Rounding stage (s2): bring the accumulator to 16 bits with pi = 32768.
	// Fewer bits are shifted up exactly; more bits are rounded half up.
	// The zero vector reads as heading zero.
	// ------------------------------------------------------------------
	logic                             v_s2;
	logic                             rdy_s2;
	logic signed [chd_pkg::MAG_W-1:0] h_s2;
	chd_pkg::zcls_t                   zcls_s2;
	logic signed [chd_pkg::MAG_W-1:0] h_rnd;
	logic [ANGLE_BITS-1:0]            z_fin;

	assign z_fin = cz_w[ANGLE_BITS];

	if (ANGLE_BITS > chd_pkg::MAG_W) begin : g_round_down
		localparam int RS = ANGLE_BITS - chd_pkg::MAG_W;
		localparam logic [ANGLE_BITS:0] HALF = (ANGLE_BITS+1)'(1) << (RS - 1);
		logic signed [ANGLE_BITS:0] zr;
		logic signed [ANGLE_BITS:0] zsh;
		always_comb begin
			zr = $signed({z_fin[ANGLE_BITS-1], z_fin}) + $signed(HALF);
			zsh = zr >>> RS;
			h_rnd = zsh[chd_pkg::MAG_W-1:0];
		end
	end else if (ANGLE_BITS < chd_pkg::MAG_W) begin : g_round_up
		assign h_rnd = {z_fin, (chd_pkg::MAG_W-ANGLE_BITS)'(0)};
	end else begin : g_round_same
		assign h_rnd = z_fin;
	end

	assign crdy_w[ANGLE_BITS] = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= cv_w[ANGLE_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && cv_w[ANGLE_BITS]) begin
			h_s2 <= cside_w[ANGLE_BITS].zero_vec ? '0 : h_rnd;
			zcls_s2 <= cside_w[ANGLE_BITS].zcls;
		end
	end

	// ------------------------------------------------------------------
	// LED stage (s3): pick the LED pattern. Sixteen range tests are checked
	// in a fixed order and the last one that holds decides; bands around
	// the odd multiples of pi/8 light two neighbours.
	// ------------------------------------------------------------------
	logic                             v_s3;
	logic                             rdy_s3;
	logic [chd_pkg::LED_W-1:0]        led_s3;
	logic signed [chd_pkg::MAG_W-1:0] h_s3;
	chd_pkg::zcls_t                   zcls_s3;
	logic [chd_pkg::BAND_W-1:0]       band_sat;
	logic [chd_pkg::LED_W-1:0]        led_nx;

	function automatic logic in_range(input logic signed [17:0] h,
		input logic signed [17:0] lo, input logic signed [17:0] hi);
		return (h >= lo) && (h <= hi);
	endfunction

	function automatic logic [chd_pkg::LED_W-1:0] compass(input logic signed [17:0] h,
		input logic signed [17:0] e);
		logic [chd_pkg::LED_W-1:0] p;
		p = 8'h00;
		if (in_range(h, -Q1 + e, Q1 - e)) p = 8'h01;
		if (in_range(h, Q1 - e, Q1 + e)) p = 8'h03;
		if (in_range(h, Q1 + e, Q3 - e)) p = 8'h02;
		if (in_range(h, Q3 - e, Q3 + e)) p = 8'h06;
		if (in_range(h, Q3 + e, Q5 - e)) p = 8'h04;
		if (in_range(h, Q5 - e, Q5 + e)) p = 8'h0C;
		if (in_range(h, Q5 + e, Q7 - e)) p = 8'h08;
		if (in_range(h, Q7 - e, Q7 + e)) p = 8'h18;
		if ((h >= Q7 + e) || (h <= -Q7 - e)) p = 8'h10;
		if (in_range(h, -Q7 - e, -Q7 + e)) p = 8'h30;
		if (in_range(h, -Q7 + e, -Q5 - e)) p = 8'h20;
		if (in_range(h, -Q5 - e, -Q5 + e)) p = 8'h60;
		if (in_range(h, -Q5 + e, -Q3 - e)) p = 8'h40;
		if (in_range(h, -Q3 - e, -Q3 + e)) p = 8'hC0;
		if (in_range(h, -Q3 + e, -Q1 - e)) p = 8'h80;
		if (in_range(h, -Q1 - e, -Q1 + e)) p = 8'h81;
		return p;
	endfunction

	// A band wider than an eighth of pi is held at an eighth of pi.
	assign band_sat = (band_q > chd_pkg::BAND_W'(chd_pkg::EIGHTH))
		? chd_pkg::BAND_W'(chd_pkg::EIGHTH) : band_q;

	always_comb begin
		case (zcls_s2)
			chd_pkg::ZCLS_ALL_ON:  led_nx = 8'hFF;
			chd_pkg::ZCLS_ALL_OFF: led_nx = 8'h00;
			chd_pkg::ZCLS_COMPASS: led_nx = compass(18'(h_s2), $signed({5'd0, band_sat}));
			default:               led_nx = 8'h00;
		endcase
	end

	assign rdy_s3 = !v_s3 || result.ready;
	assign rdy_s2 = !v_s2 || rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			led_s3 <= led_nx;
			h_s3 <= h_s2;
			zcls_s3 <= zcls_s2;
		end
	end

	assign result.valid = v_s3;
	assign result.led_pattern = led_s3;
	assign result.heading_angle = h_s3;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------

	// The input is held off only when every stage up to the output is full
	// and the output beat is not being taken.
	a_backpressure_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (v_s1 && v_s2 && v_s3 && !result.ready))
		else $error("input stalled while the pipeline has room");

	// A heading-decided pattern lights one LED or two neighbours, never more.
	a_compass_one_or_two: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && zcls_s3 == chd_pkg::ZCLS_COMPASS) |->
		($countones(led_s3) == 1 || $countones(led_s3) == 2))
		else $error("compass pattern lights a wrong number of LEDs");

	// A beat in the rounding stage moves to the output whenever the output can take it.
	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && rdy_s3) |=> v_s3)
		else $error("beat lost between rounding and LED stages");

endmodule

// File: rtl/chd_cordic_stage.sv
// One registered vectoring CORDIC iteration with valid/ready flow control.
module chd_cordic_stage #(
	parameter int ANGLE_BITS = 16,
	parameter int STEP = 0
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [chd_pkg::XY_W-1:0]   in_x,
	input  logic signed [chd_pkg::XY_W-1:0]   in_y,
	input  logic [ANGLE_BITS-1:0]             in_z,
	input  chd_pkg::side_t                    in_side,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [chd_pkg::XY_W-1:0]   out_x,
	output logic signed [chd_pkg::XY_W-1:0]   out_y,
	output logic [ANGLE_BITS-1:0]             out_z,
	output chd_pkg::side_t                    out_side
);

	localparam logic [31:0] STEP_FULL = chd_pkg::atan_step(ANGLE_BITS, STEP);
	localparam logic [ANGLE_BITS-1:0] STEP_ANG = STEP_FULL[ANGLE_BITS-1:0];

	logic                            v_s1;
	logic signed [chd_pkg::XY_W-1:0] x_s1;
	logic signed [chd_pkg::XY_W-1:0] y_s1;
	logic [ANGLE_BITS-1:0]           z_s1;
	chd_pkg::side_t                  side_s1;

	logic signed [chd_pkg::XY_W-1:0] xs;
	logic signed [chd_pkg::XY_W-1:0] ys;
	logic signed [chd_pkg::XY_W-1:0] x_nx;
	logic signed [chd_pkg::XY_W-1:0] y_nx;
	logic [ANGLE_BITS-1:0]           z_nx;

	assign in_ready = !v_s1 || out_ready;

	// Rotate toward the x axis by the sign of y.
	always_comb begin
		xs = in_x >>> STEP;
		ys = in_y >>> STEP;
		if (!in_y[chd_pkg::XY_W-1]) begin
			x_nx = in_x + ys;
			y_nx = in_y - xs;
			z_nx = in_z + STEP_ANG;
		end else begin
			x_nx = in_x - ys;
			y_nx = in_y + xs;
			z_nx = in_z - STEP_ANG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
			side_s1 <= in_side;
		end
	end

	assign out_valid = v_s1;
	assign out_x = x_s1;
	assign out_y = y_s1;
	assign out_z = z_s1;
	assign out_side = side_s1;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the compass heading block: directed samples, then random ones.
`timescale 1ns / 100ps

module tb_top;

	// CORDIC depth of the block as built, and the width of the heading.
	localparam int CORDIC_STAGES = 16;
	// An eighth of pi in binary angle units where pi is 32768.
	localparam int OCTANT = 4096;
	localparam longint HALF_TURN = 64'sd32768;
	// The pipeline is CORDIC_STAGES + 3 deep; the tail wait covers it with margin.
	localparam int TAIL_CYCLES = CORDIC_STAGES + 3 + 16;
	// Even a slow run stays far below this many cycles.
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_SAMPLES = 325;
	localparam int DIR_ROWS = 24;
	localparam int PRINT_CAP = 200;
	// Index 3 decodes to no register, so writes to it must change nothing.
	localparam logic [chd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	// Arctangent of 2^-i with pi = 2^31, one entry per CORDIC stage.
	localparam logic [31:0] ARCTAN_PI31 [CORDIC_STAGES] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
	};

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	// One result beat as the block should produce it.
	typedef struct packed {
		logic [chd_pkg::LED_W-1:0] led_pattern;
		logic [chd_pkg::MAG_W-1:0] heading_angle;
	} compass_result_t;

	// One row of the directed part. When known is set, led and heading hold the
	// expected result typed in by hand; otherwise the predictor supplies it.
	typedef struct packed {
		logic [chd_pkg::MAG_W-1:0] x;
		logic [chd_pkg::MAG_W-1:0] y;
		logic [chd_pkg::MAG_W-1:0] z;
		logic                      known;
		logic [chd_pkg::LED_W-1:0] led;
		logic [chd_pkg::MAG_W-1:0] heading;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [chd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [chd_pkg::MAG_W-1:0] cfg_wdata;
	logic recv_ready = 1'b0;

	chd_sample_if sample_ch ();
	chd_result_if result_ch ();

	assign result_ch.ready = recv_ready;

	compass_heading_led_indicator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copies of the configuration registers, updated as they are written.
	logic signed [chd_pkg::MAG_W-1:0] z_high_q = 16'sd240;
	logic signed [chd_pkg::MAG_W-1:0] z_low_q = -16'sd310;
	logic [chd_pkg::BAND_W-1:0] band_q = 13'd819;

	compass_result_t pending_results [$];
	idle_mode_t idle_mode = IDLE_NONE;
	int cycle_count = 0;
	int mismatch_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int settings_loaded = 0;

	// Samples with x = y = 0 are the zero vector; the top rows hit the z limits
	// exactly and one step past them, with the reset limits of 240 and -310.
	directed_row_t directed_tab [DIR_ROWS] = '{
		'{16'd0, 16'd0, 16'd0, 1'b1, 8'h01, 16'd0},
		'{16'd0, 16'd0, 16'd241, 1'b1, 8'hFF, 16'd0},
		'{16'd0, 16'd0, 16'd240, 1'b1, 8'h01, 16'd0},
		'{16'd0, 16'd0, -16'sd310, 1'b1, 8'h01, 16'd0},
		'{16'd0, 16'd0, -16'sd311, 1'b1, 8'h00, 16'd0},
		'{16'd0, 16'd0, 16'h7FFF, 1'b1, 8'hFF, 16'd0},
		'{16'd0, 16'd0, 16'h8000, 1'b1, 8'h00, 16'd0},
		'{16'd100, 16'd0, 16'd0, 1'b0, 8'h00, 16'd0},
		'{-16'sd100, 16'd0, 16'd0, 1'b0, 8'h00, 16'd0},
		'{-16'sd100, 16'd1, 16'd0, 1'b0, 8'h00, 16'd0},
		'{-16'sd100, -16'sd1, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'd0, 16'd100, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'd0, -16'sd100, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'd100, 16'd100, 16'd0, 1'b0, 8'h00, 16'd0},
		'{-16'sd100, 16'd100, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'd100, 16'd41, 16'd0, 1'b0, 8'h00, 16'd0},
		'{-16'sd100, -16'sd41, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'h7FFF, 16'h7FFF, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'h8000, 16'h8000, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'h7FFF, 16'h8000, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'h8000, 16'h7FFF, 16'd0, 1'b0, 8'h00, 16'd0},
		'{16'h8000, 16'd0, 16'h8000, 1'b0, 8'h00, 16'd0},
		'{16'h7FFF, 16'd0, 16'h7FFF, 1'b0, 8'h00, 16'd0},
		'{16'h8000, -16'sd1, 16'd100, 1'b0, 8'h00, 16'd0}
	};

	logic [chd_pkg::MAG_W-1:0] corner_vals [5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
		16'h0001};

	// The clock runs at 100 MHz.
	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Vectoring CORDIC on x and y scaled by 2^8. A vector in the left half plane is
	// first turned by pi, then every stage rotates toward the x axis and adds or
	// subtracts the rounded arctangent. The angle wraps to 16 bits, so +pi reads -32768.
	function automatic logic signed [chd_pkg::MAG_W-1:0] cordic_heading(
		input logic signed [chd_pkg::MAG_W-1:0] ax, input logic signed [chd_pkg::MAG_W-1:0] ay);
		longint vx, vy, angle, sx, sy, rot;
		int i;
		if (ax == 0 && ay == 0)
			return '0;
		vx = longint'(ax) * 256;
		vy = longint'(ay) * 256;
		angle = 0;
		if (vx < 0) begin
			angle = (vy >= 0) ? HALF_TURN : -HALF_TURN;
			vx = -vx;
			vy = -vy;
		end
		for (i = 0; i < CORDIC_STAGES; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			// Round the pi = 2^31 table entry to nearest at pi = 2^15.
			rot = longint'(({32'd0, ARCTAN_PI31[4'(i)]} + 64'd32768) >> 16);
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				angle = angle + rot;
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				angle = angle - rot;
			end
		end
		return angle[chd_pkg::MAG_W-1:0];
	endfunction

	// Sixteen sectors are tested in a fixed order and a later hit overrides an
	// earlier one, which settles headings that sit exactly on a sector edge.
	// Even sectors light one LED around a multiple of pi/4; odd sectors are the
	// two-LED bands of width 2*e around the odd multiples of pi/8. Sector 8 is the
	// one around pi, which straddles the wrap of the heading.
	function automatic logic [chd_pkg::LED_W-1:0] compass_leds(input int h, input int e);
		logic [chd_pkg::LED_W-1:0] leds;
		int j, c;
		leds = '0;
		for (j = 0; j < 16; j++) begin
			c = (j < 8) ? j * OCTANT : (j - 16) * OCTANT;
			if (j == 8) begin
				if (h >= 7 * OCTANT + e || h <= -7 * OCTANT - e)
					leds = 8'h10;
			end else if (j % 2 == 0) begin
				if (h >= c - OCTANT + e && h <= c + OCTANT - e)
					leds = 8'd1 << (j / 2);
			end else begin
				if (h >= c - e && h <= c + e)
					leds = (8'd1 << ((j - 1) / 2)) | (8'd1 << (((j + 1) / 2) % 8));
			end
		end
		return leds;
	endfunction

	// Expected result for one sample under the current register shadow. The high
	// z test comes first, so with crossed limits it is the one that wins.
	function automatic compass_result_t predict_compass(
		input logic signed [chd_pkg::MAG_W-1:0] px,
		input logic signed [chd_pkg::MAG_W-1:0] py,
		input logic signed [chd_pkg::MAG_W-1:0] pz);
		compass_result_t res;
		int e;
		res.heading_angle = cordic_heading(px, py);
		// A band wider than an eighth of pi is clamped to it.
		e = (band_q > 13'd4096) ? OCTANT : int'(band_q);
		if (pz > z_high_q)
			res.led_pattern = 8'hFF;
		else if (pz < z_low_q)
			res.led_pattern = 8'h00;
		else
			res.led_pattern = compass_leds(int'(signed'(res.heading_angle)), e);
		return res;
	endfunction

	// Decides from the current mode whether the given side idles.
	function automatic bit idles(input bit sender_side);
		case (idle_mode)
			IDLE_SENDER: return sender_side && ($urandom_range(99, 0) < 55);
			IDLE_RECEIVER: return !sender_side && ($urandom_range(99, 0) < 55);
			IDLE_BOTH: return $urandom_range(99, 0) < 33;
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [chd_pkg::MAG_W-1:0] got,
		input logic [chd_pkg::MAG_W-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("MISMATCH cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what,
				got, want);
		mismatch_count++;
	endtask

	// Offers one sample beat and waits for it to be taken. Valid only drops when a
	// gap is chosen, so back-to-back beats keep it high across the edge. The
	// expectation is queued at the edge that accepts the beat.
	task automatic send_sample(input logic [chd_pkg::MAG_W-1:0] sx,
		input logic [chd_pkg::MAG_W-1:0] sy, input logic [chd_pkg::MAG_W-1:0] sz,
		input logic known, input compass_result_t known_res);
		if (idles(1'b1)) begin
			sample_ch.valid <= 1'b0;
			do @(posedge clk); while (idles(1'b1));
		end
		sample_ch.valid <= 1'b1;
		sample_ch.mag_x <= sx;
		sample_ch.mag_y <= sy;
		sample_ch.mag_z <= sz;
		do @(posedge clk); while (!sample_ch.ready);
		pending_results.push_back(known ? known_res : predict_compass(sx, sy, sz));
		samples_sent++;
	endtask

	// Closes the stream and waits until every queued result has come back, so the
	// registers can be written with nothing in flight.
	task automatic drain_pipeline();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [chd_pkg::CFG_IDX_W-1:0] idx,
		input logic [chd_pkg::MAG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		case (idx)
			chd_pkg::REG_Z_HIGH: z_high_q = data;
			chd_pkg::REG_Z_LOW: z_low_q = data;
			chd_pkg::REG_BAND: band_q = data[chd_pkg::BAND_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all three registers and the spare index back to back; the enable only
	// drops after the last write.
	task automatic load_settings(input logic [chd_pkg::MAG_W-1:0] hi,
		input logic [chd_pkg::MAG_W-1:0] lo, input logic [chd_pkg::MAG_W-1:0] band);
		write_reg(chd_pkg::REG_Z_HIGH, hi);
		write_reg(chd_pkg::REG_Z_LOW, lo);
		write_reg(chd_pkg::REG_BAND, band);
		write_reg(REG_SPARE, 16'($urandom));
		cfg_we <= 1'b0;
		settings_loaded++;
	endtask

	// Random samples for one register setting. The idle mode steps through all four
	// kinds over the phase, starting one kind further on in each phase.
	task automatic random_samples(input int count, input int phase_idx);
		logic [chd_pkg::MAG_W-1:0] rx, ry, rz, swap;
		compass_result_t none;
		int n, m, span;
		none = '0;
		for (n = 0; n < count; n++) begin
			idle_mode = idle_mode_t'(((n * 4) / count + phase_idx) % 4);
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4: begin
					rx = 16'($urandom);
					ry = 16'($urandom);
				end
				5, 6: begin
					// Tiny vectors, the zero vector among them.
					rx = 16'(int'($urandom_range(8, 0)) - 4);
					ry = 16'(int'($urandom_range(8, 0)) - 4);
				end
				7: begin
					// Close to an odd multiple of pi/8, where the two-LED bands sit.
					m = int'($urandom_range(20000, 1));
					rx = 16'(m);
					ry = 16'(m * 414 / 1000 + int'($urandom_range(40, 0)) - 20);
					if ($urandom_range(1, 0)) begin
						swap = rx;
						rx = ry;
						ry = swap;
					end
					if ($urandom_range(1, 0))
						rx = -rx;
					if ($urandom_range(1, 0))
						ry = -ry;
				end
				8: begin
					// On an axis.
					rx = $urandom_range(1, 0) ? 16'($urandom) : 16'd0;
					ry = (rx == 0) ? 16'($urandom) : 16'd0;
				end
				default: begin
					rx = corner_vals[3'($urandom_range(4, 0))];
					ry = corner_vals[3'($urandom_range(4, 0))];
				end
			endcase
			// Most z values fall between the limits so that the compass decides.
			case ($urandom_range(9, 0))
				0, 1, 2, 3, 4, 5: begin
					if (z_low_q <= z_high_q) begin
						span = int'(z_high_q) - int'(z_low_q);
						rz = 16'(int'(z_low_q) + int'($urandom_range(span, 0)));
					end else
						rz = 16'($urandom);
				end
				6: rz = 16'(int'(z_high_q) + int'($urandom_range(2, 0)) - 1);
				7: rz = 16'(int'(z_low_q) + int'($urandom_range(2, 0)) - 1);
				default: rz = 16'($urandom);
			endcase
			send_sample(rx, ry, rz, 1'b0, none);
		end
	endtask

	// Result side: a beat moves when valid and ready were both high before the
	// edge. It is checked against the oldest expectation, then ready is chosen
	// for the next cycle.
	always @(posedge clk) begin
		compass_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding, led_pattern",
					16'(result_ch.led_pattern), 16'd0);
			end else begin
				want = pending_results.pop_front();
				if (result_ch.led_pattern !== want.led_pattern)
					report_mismatch("led_pattern", 16'(result_ch.led_pattern),
						16'(want.led_pattern));
				if (result_ch.heading_angle !== want.heading_angle)
					report_mismatch("heading_angle", result_ch.heading_angle,
						want.heading_angle);
				results_checked++;
			end
		end
		recv_ready <= arst_n && !idles(1'b0);
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [chd_pkg::MAG_W-1:0] lim_a, lim_b;
		compass_result_t typed;
		int k, p;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= chd_pkg::REG_Z_HIGH;
		cfg_wdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.mag_x <= '0;
		sample_ch.mag_y <= '0;
		sample_ch.mag_z <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The directed rows run on the reset values of the registers, so the z
		// limit rows also show that reset loaded 240 and -310.
		idle_mode = IDLE_BOTH;
		for (k = 0; k < DIR_ROWS; k++) begin
			typed.led_pattern = directed_tab[5'(k)].led;
			typed.heading_angle = directed_tab[5'(k)].heading;
			send_sample(directed_tab[5'(k)].x, directed_tab[5'(k)].y, directed_tab[5'(k)].z,
				directed_tab[5'(k)].known, typed);
		end
		drain_pipeline();

		// Each random phase runs under its own register setting. The first ones are
		// the extremes: limits wide open with zero-width bands, crossed limits with
		// the widest band, a band beyond the clamp with all upper data bits set,
		// and a one-unit band.
		for (p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: load_settings(16'h7FFF, 16'h8000, 16'd0);
				1: load_settings(16'h8000, 16'h7FFF, 16'd4096);
				2: load_settings(16'd0, 16'd0, 16'hFFFF);
				3: load_settings(16'd1000, -16'sd1000, 16'd1);
				4: begin
					lim_a = 16'($urandom);
					lim_b = 16'($urandom);
					if (lim_a >= lim_b)
						load_settings(lim_a, lim_b, 16'($urandom_range(4096, 0)));
					else
						load_settings(lim_b, lim_a, 16'($urandom_range(4096, 0)));
				end
				default: load_settings(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			random_samples(PHASE_SAMPLES, p);
			drain_pipeline();
		end

		// Nothing is outstanding; give a stray beat time to show up.
		idle_mode = IDLE_NONE;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d samples under %0d register settings plus reset values.",
			samples_sent, settings_loaded);
		$display("Checked %0d result beats, %0d mismatches found.", results_checked,
			mismatch_count);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
